[rtl/srt_pkg.sv]
// shared types and constants of the shortest-remaining-time scheduler
`timescale 1ns / 1ps
`default_nettype none
package srt_pkg;

   localparam logic [1:0]  MODE_CLEAR = 2'd0;
   localparam logic [1:0]  MODE_LOAD  = 2'd1;
   localparam logic [1:0]  MODE_TICK  = 2'd2;

   localparam logic [23:0] TIME_MAX   = 24'hFFFFFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic apply;       // clear, load or unused mode taken this cycle
      logic tick_start;  // tick taken, restart the minimum search
      logic scan_rd;     // slot tables read at the scan address
      logic commit;      // run the chosen slot and report
   } ctrl_cmd_type;

endpackage
`default_nettype wire

[rtl/shortest_remaining_time_scheduler_unit.sv]
// top level of the shortest-remaining-time scheduler
`timescale 1ns / 1ps
`default_nettype none
// A command is taken when start is high and busy is low, and gives exactly one
// result, shown for one cycle with rsp_strobe; the receiver cannot stall it.
// Clear and load results appear in the cycle after the transfer and busy stays
// low, so such commands may follow every cycle. A tick walks the slot tables
// one entry per cycle through their single read port to find the job with least
// remaining time, then passes through a drain state for the last read and a
// commit state; no new command is taken while it runs, and busy drops in the
// cycle in which its result appears, so the next transfer can be taken in that
// same cycle. Loads to slot numbers at or above SLOTS are ignored.
module shortest_remaining_time_scheduler_unit #(
   parameter int SLOTS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic [1:0]   req_mode,
   input  wire logic [3:0]   req_slot,
   input  wire logic [15:0]  req_arrival,
   input  wire logic [15:0]  req_burst,
   output logic              rsp_strobe,
   output logic [3:0]        rsp_running_slot,
   output logic              rsp_idle,
   output logic              rsp_finished,
   output logic [23:0]       rsp_turnaround,
   output logic [23:0]       rsp_waiting,
   output logic [23:0]       rsp_now,
   output logic              rsp_all_done
);
   import srt_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);

   ctrl_cmd_type       cmd;
   logic [IDX_W-1:0]   rd_addr;

   srt_ctrl #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .busy     (busy),
      .cmd      (cmd),
      .rd_addr  (rd_addr)
   );

   srt_dpath #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .rd_addr          (rd_addr),
      .req_mode         (req_mode),
      .req_slot         (req_slot),
      .req_arrival      (req_arrival),
      .req_burst        (req_burst),
      .rsp_strobe       (rsp_strobe),
      .rsp_running_slot (rsp_running_slot),
      .rsp_idle         (rsp_idle),
      .rsp_finished     (rsp_finished),
      .rsp_turnaround   (rsp_turnaround),
      .rsp_waiting      (rsp_waiting),
      .rsp_now          (rsp_now),
      .rsp_all_done     (rsp_all_done)
   );

endmodule
`default_nettype wire

[rtl/srt_ctrl.sv]
// controller: sequences the slot scan and the commit of a tick
`timescale 1ns / 1ps
`default_nettype none
module srt_ctrl #(
   parameter int SLOTS = 16,
   parameter int IDX_W = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [1:0]           req_mode,
   output logic                      busy,
   output srt_pkg::ctrl_cmd_type     cmd,
   output logic [IDX_W-1:0]          rd_addr
);
   import srt_pkg::*;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_mode == MODE_TICK) begin
                  cmd.tick_start = 1'b1;
                  cnt_in         = '0;
                  state_in       = ST_SCAN;
               end else begin
                  cmd.apply = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(SLOTS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last read entry is compared this cycle
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy    = (state_ff != ST_IDLE);
   assign rd_addr = cnt_ff;

endmodule
`default_nettype wire

[rtl/srt_dpath.sv]
// datapath: slot tables, pending bits, time, minimum search and result registers
`timescale 1ns / 1ps
`default_nettype none
module srt_dpath #(
   parameter int SLOTS = 16,
   parameter int IDX_W = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  srt_pkg::ctrl_cmd_type      cmd,
   input  wire logic [IDX_W-1:0]      rd_addr,
   input  wire logic [1:0]            req_mode,
   input  wire logic [3:0]            req_slot,
   input  wire logic [15:0]           req_arrival,
   input  wire logic [15:0]           req_burst,
   output logic                       rsp_strobe,
   output logic [3:0]                 rsp_running_slot,
   output logic                       rsp_idle,
   output logic                       rsp_finished,
   output logic [23:0]                rsp_turnaround,
   output logic [23:0]                rsp_waiting,
   output logic [23:0]                rsp_now,
   output logic                       rsp_all_done
);
   import srt_pkg::*;

   // slot tables
   logic [15:0]        arr_mem [SLOTS];
   logic [15:0]        bur_mem [SLOTS];
   logic [15:0]        rem_mem [SLOTS];
   logic [15:0]        rd_arr_ff, rd_bur_ff, rd_rem_ff;

   logic               cmp_vld_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;

   logic               best_found_ff, best_found_in;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [15:0]        best_arr_ff, best_bur_ff, best_rem_ff;

   logic [SLOTS-1:0]   pending_ff, pending_in;
   logic [23:0]        time_ff, time_in;

   logic               strobe_ff;
   logic [3:0]         run_ff;
   logic               idle_ff, fin_ff, done_ff;
   logic [23:0]        tat_ff, wt_ff, now_ff;

   logic [31:0]        slot_ext;
   logic               load_ok, load_we, rem_we;
   logic [IDX_W-1:0]   wr_idx, rem_idx;
   logic [15:0]        rem_wdata, rem_dec;
   logic               cand_ok, better;
   logic               fin;
   logic [23:0]        time_inc, arr_ext, bur_ext, tat_raw, tat, wt;
   logic [31:0]        sel_ext;

   assign slot_ext = {28'd0, req_slot};
   assign load_ok  = (slot_ext < 32'(SLOTS));
   assign wr_idx   = slot_ext[IDX_W-1:0];
   assign load_we  = cmd.apply && (req_mode == MODE_LOAD) && load_ok;

   assign rem_dec   = best_rem_ff - 16'd1;
   assign rem_we    = load_we || (cmd.commit && best_found_ff);
   assign rem_idx   = load_we ? wr_idx : best_idx_ff;
   assign rem_wdata = load_we ? req_burst : rem_dec;

   always_ff @(posedge clock) begin
      if (load_we) begin
         arr_mem[wr_idx] <= req_arrival;
         bur_mem[wr_idx] <= req_burst;
      end
      if (rem_we) begin
         rem_mem[rem_idx] <= rem_wdata;
      end
      rd_arr_ff <= arr_mem[rd_addr];
      rd_bur_ff <= bur_mem[rd_addr];
      rd_rem_ff <= rem_mem[rd_addr];
   end

   // one entry compared per cycle, strict compare keeps the lower slot on full ties
   assign cand_ok = cmp_vld_ff && pending_ff[cmp_idx_ff]
                    && ({8'd0, rd_arr_ff} <= time_ff);
   assign better  = !best_found_ff || (rd_rem_ff < best_rem_ff)
                    || ((rd_rem_ff == best_rem_ff) && (rd_arr_ff < best_arr_ff));

   always_comb begin
      best_found_in = best_found_ff;
      if (cmd.tick_start) begin
         best_found_in = 1'b0;
      end else if (cand_ok && better) begin
         best_found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff    <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         cmp_vld_ff    <= cmd.scan_rd;
         best_found_ff <= best_found_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= rd_addr;
      if (cand_ok && better) begin
         best_idx_ff <= cmp_idx_ff;
         best_arr_ff <= rd_arr_ff;
         best_bur_ff <= rd_bur_ff;
         best_rem_ff <= rd_rem_ff;
      end
   end

   // commit arithmetic
   assign time_inc = (time_ff == TIME_MAX) ? time_ff : time_ff + 24'd1;
   assign arr_ext  = {8'd0, best_arr_ff};
   assign bur_ext  = {8'd0, best_bur_ff};
   assign tat_raw  = time_inc - arr_ext;
   assign tat      = (time_inc >= arr_ext) ? tat_raw : 24'd0;
   assign wt       = (tat >= bur_ext) ? tat - bur_ext : 24'd0;
   assign fin      = best_found_ff && (rem_dec == 16'd0);
   assign sel_ext  = 32'(best_idx_ff);

   always_comb begin
      pending_in = pending_ff;
      time_in    = time_ff;
      if (cmd.apply) begin
         if (req_mode == MODE_CLEAR) begin
            pending_in = '0;
            time_in    = '0;
         end else if (load_we) begin
            // zero burst counts as already done
            pending_in[wr_idx] = (req_burst != 16'd0);
         end
      end else if (cmd.commit) begin
         time_in = time_inc;
         if (fin) begin
            pending_in[best_idx_ff] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         time_ff    <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         time_ff    <= time_in;
         strobe_ff  <= cmd.apply || cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply || cmd.commit) begin
         now_ff  <= time_in;
         done_ff <= ~|pending_in;
         if (cmd.commit && best_found_ff) begin
            run_ff  <= sel_ext[3:0];
            idle_ff <= 1'b0;
            fin_ff  <= fin;
            tat_ff  <= fin ? tat : 24'd0;
            wt_ff   <= fin ? wt : 24'd0;
         end else begin
            run_ff  <= 4'd0;
            idle_ff <= 1'b1;
            fin_ff  <= 1'b0;
            tat_ff  <= 24'd0;
            wt_ff   <= 24'd0;
         end
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_running_slot = run_ff;
   assign rsp_idle         = idle_ff;
   assign rsp_finished     = fin_ff;
   assign rsp_turnaround   = tat_ff;
   assign rsp_waiting      = wt_ff;
   assign rsp_now          = now_ff;
   assign rsp_all_done     = done_ff;

endmodule
`default_nettype wire

[rtl/srt_checker.sv]
// port-level checks of the scheduler and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none
module srt_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         start,
   input wire logic         busy,
   input wire logic [1:0]   req_mode,
   input wire logic         rsp_strobe,
   input wire logic [3:0]   rsp_running_slot,
   input wire logic         rsp_idle,
   input wire logic         rsp_finished,
   input wire logic [23:0]  rsp_turnaround,
   input wire logic [23:0]  rsp_waiting
);
   import srt_pkg::*;

   // a result always comes with the block free again
   a_strobe_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // non-tick transfers answer in the very next cycle
   a_simple_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode != MODE_TICK) |=> rsp_strobe)
      else $error("clear or load result missing");

   // an idle result carries no completion
   a_idle_no_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_idle) |->
         (!rsp_finished && rsp_turnaround == 24'd0 && rsp_running_slot == 4'd0))
      else $error("idle result with completion data");

   // waiting never exceeds turnaround
   a_wait_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_finished) |-> (rsp_waiting <= rsp_turnaround))
      else $error("waiting above turnaround");

endmodule

bind shortest_remaining_time_scheduler_unit srt_checker u_srt_checker (.*);
`default_nettype wire
